/* sv/astep_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astep_pkg
// Shared widths, reset values, register indexes and divider interface types
// for the adaptive step sequencer.
// ----------------------------------------------------------------------------
package astep_pkg;

    // position accumulator width
    localparam int POS_BITS  = 40;
    localparam int SUB_W     = 13;
    localparam int STRIDE_W  = 11;
    localparam int COUNT_W   = 21;
    // stride * subticks fits in 24 bits for any register value
    localparam int PERIOD_W  = 24;
    // dividend width: wide enough for the position and the step count
    localparam int DIVD_W    = (POS_BITS > COUNT_W) ? POS_BITS : COUNT_W;

    localparam int OUT_POS_W = 40;
    localparam int TDATA_W   = 104;

    localparam logic [COUNT_W-1:0]  COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [SUB_W-1:0]    SUBTICKS_RST   = SUB_W'(128);
    localparam logic [STRIDE_W-1:0] STRIDE_RST     = STRIDE_W'(1);
    localparam logic [COUNT_W-1:0]  TOTAL_RST      = COUNT_W'(11);

    // configuration register indexes
    localparam logic [1:0] CFG_SUBTICKS = 2'd0;
    localparam logic [1:0] CFG_STRIDE   = 2'd1;
    localparam logic [1:0] CFG_TOTAL    = 2'd2;

    // request to the serial divider
    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    // divider result, valid while done is high
    typedef struct packed {
        logic                done;
        logic [DIVD_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } div_res_t;

endpackage

/* sv/adaptive_step_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_step_sequencer
// Adaptive integration step control in integer sub-ticks: step halving on an
// even-size failure, doubling on success, capped at one whole step and the boundary.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per finished attempt, s_tdata[0] = attempt_ok.
//   m_ channel: one result item per input item describing the next attempt.
//   cfg channel: register writes (index 0 subticks, 1 stride, 2 total steps),
//   always ready; write only while no item is in flight.
// Passes:
//   Each item runs up to four passes through one shared serial divider
//   (boundary test, sample index, record_now, record_next); the boundary test
//   is skipped when no advance is made (failed even-size attempt or finished
//   run). s_tready is low until the item's result is loaded into the output
//   register.
// Reset:
//   aresetn (sync, active low) restores the register defaults, position 0,
//   step size 128, counts and freeze flag cleared, no pending result.
// Stalls:
//   The result sits in an output register; a new item may be accepted while
//   it waits, and that item's result holds until the register is taken.
// ----------------------------------------------------------------------------
module adaptive_step_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [0] attempt_ok, [7:1] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    // m_tdata: [39:0] position_ticks, [52:40] step_ticks, [73:53] whole_steps,
    //          [94:74] sample_index, [95] record_now, [96] record_next,
    //          [97] frozen, [98] finished, [103:99] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [astep_pkg::TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [astep_pkg::COUNT_W-1:0]  cfg_data
);
    import astep_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_IDX,
        ST_NOW,
        ST_NEXT,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic                go_reg;

    // configuration
    logic [SUB_W-1:0]    subticks_reg;
    logic [STRIDE_W-1:0] stride_cfg_reg;
    logic [COUNT_W-1:0]  total_reg;

    // sequencer state
    logic [POS_BITS-1:0] position_reg;
    logic [SUB_W-1:0]    step_size_reg;
    logic [COUNT_W-1:0]  step_count_reg;
    logic                freeze_reg;

    // per-item working values
    logic                ok_reg;
    logic [SUB_W-1:0]    msize_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [POS_BITS-1:0] cand_reg;
    logic [COUNT_W-1:0]  sidx_reg;
    logic                done_reg;
    logic                rnow_reg;
    logic                rnext_reg;

    // output register
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;

    logic [SUB_W-1:0]    eff_sub;
    logic [STRIDE_W-1:0] eff_str;
    logic                active;
    logic [SUB_W-1:0]    rem_low;
    logic [SUB_W-1:0]    room;
    logic [SUB_W:0]      ext;
    logic [SUB_W:0]      ns_a;
    logic [SUB_W:0]      ns;
    logic [POS_BITS-1:0] pos_plus;

    div_req_t            div_req;
    div_res_t            div_res;

    astep_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    // zero sizes count as one
    assign eff_sub = (subticks_reg == '0) ? SUB_W'(1) : subticks_reg;
    assign eff_str = (stride_cfg_reg == '0) ? STRIDE_W'(1) : stride_cfg_reg;
    assign active  = step_count_reg < total_reg;

    // next size after a success: min(2*size, full step, distance to boundary)
    assign rem_low = div_res.remainder[SUB_W-1:0];
    assign room    = msize_reg - rem_low;
    assign ext     = {step_size_reg, 1'b0};
    assign ns_a    = (ext < {1'b0, msize_reg}) ? ext : {1'b0, msize_reg};
    assign ns      = ({1'b0, room} < ns_a) ? {1'b0, room} : ns_a;

    assign pos_plus = position_reg + POS_BITS'(step_size_reg);

    // divider operand select per pass
    always_comb begin
        div_req.start    = go_reg;
        div_req.dividend = DIVD_W'(position_reg);
        div_req.divisor  = period_reg;
        case (state_reg)
            ST_ADV: begin
                div_req.dividend = DIVD_W'(cand_reg);
                div_req.divisor  = PERIOD_W'(msize_reg);
            end
            ST_IDX: begin
                div_req.dividend = DIVD_W'(step_count_reg);
                div_req.divisor  = PERIOD_W'(stride_reg);
            end
            ST_NOW: begin
                div_req.dividend = DIVD_W'(position_reg);
                div_req.divisor  = period_reg;
            end
            ST_NEXT: begin
                div_req.dividend = DIVD_W'(pos_plus);
                div_req.divisor  = period_reg;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            go_reg         <= 1'b0;
            subticks_reg   <= SUBTICKS_RST;
            stride_cfg_reg <= STRIDE_RST;
            total_reg      <= TOTAL_RST;
            position_reg   <= '0;
            step_size_reg  <= SUBTICKS_RST;
            step_count_reg <= '0;
            freeze_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            go_reg <= 1'b0;

            // register writes
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SUBTICKS: subticks_reg   <= cfg_data[SUB_W-1:0];
                    CFG_STRIDE:   stride_cfg_reg <= cfg_data[STRIDE_W-1:0];
                    CFG_TOTAL:    total_reg      <= cfg_data;
                    default:      ;
                endcase
            end

            // output taken; a reload in ST_OUT sets it again
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ok_reg     <= s_tdata[0];
                        msize_reg  <= eff_sub;
                        stride_reg <= eff_str;
                        period_reg <= PERIOD_W'(eff_sub) * PERIOD_W'(eff_str);
                        cand_reg   <= pos_plus;
                        go_reg     <= 1'b1;
                        if (active && (s_tdata[0] || step_size_reg[0])) begin
                            state_reg <= ST_ADV;
                        end else begin
                            if (active) begin
                                step_size_reg <= step_size_reg >> 1;
                            end
                            state_reg <= ST_IDX;
                        end
                    end
                end
                ST_ADV: begin
                    if (div_res.done) begin
                        position_reg <= cand_reg;
                        if (rem_low == '0 && step_count_reg != COUNT_MAX) begin
                            step_count_reg <= step_count_reg + COUNT_W'(1);
                        end
                        if (ok_reg) begin
                            step_size_reg <= ns[SUB_W-1:0];
                        end else begin
                            freeze_reg <= 1'b1;
                        end
                        go_reg    <= 1'b1;
                        state_reg <= ST_IDX;
                    end
                end
                ST_IDX: begin
                    if (div_res.done) begin
                        sidx_reg  <= div_res.quotient[COUNT_W-1:0];
                        done_reg  <= step_count_reg >= total_reg;
                        go_reg    <= 1'b1;
                        state_reg <= ST_NOW;
                    end
                end
                ST_NOW: begin
                    if (div_res.done) begin
                        rnow_reg  <= done_reg || (div_res.remainder == '0);
                        go_reg    <= 1'b1;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (div_res.done) begin
                        rnext_reg <= div_res.remainder == '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {5'b0, done_reg, freeze_reg, rnext_reg, rnow_reg,
                                         sidx_reg, step_count_reg, step_size_reg,
                                         OUT_POS_W'(position_reg)};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // step size never collapses to zero
    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        step_size_reg != '0)
        else $error("step size reached zero");

    // whole-step count moves by at most one per cycle
    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_count_reg == $past(step_count_reg)) ||
        (step_count_reg == $past(step_count_reg) + COUNT_W'(1)))
        else $error("step count jumped");

    // freeze flag is sticky
    a_freeze_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        freeze_reg |=> freeze_reg)
        else $error("freeze flag cleared");

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after accept");
`endif

endmodule

/* sv/astep_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astep_div
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle with quotient and remainder.
// ----------------------------------------------------------------------------
module astep_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  astep_pkg::div_req_t req,
    output astep_pkg::div_res_t res
);
    import astep_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DIVD_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [DIVD_W-1:0]   quo_reg;
    logic [PERIOD_W-1:0] dsr_reg;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                fits;

    // trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive step sequencer. A short directed pass
// runs through step halving down to the forced odd step, zero and extreme
// register values and a finished run. Random phases follow, each with fresh
// register settings. Every result is checked field by field against a typed
// plan or a local step-control model, with random idle cycles on both streams in most phases.
// ----------------------------------------------------------------------------
module tb_top;
    import astep_pkg::*;

    localparam int          RAND_ATTEMPTS = 400;
    localparam int          DRAIN_CYCLES  = 200;
    localparam logic [63:0] POS_MASK      = (64'd1 << POS_BITS) - 64'd1;

    // one result item, split into its fields
    typedef struct packed {
        logic [39:0]        position_ticks;
        logic [SUB_W-1:0]   step_ticks;
        logic [COUNT_W-1:0] whole_steps;
        logic [COUNT_W-1:0] sample_index;
        logic               record_now;
        logic               record_next;
        logic               frozen;
        logic               finished;
    } attempt_plan_t;

    // directed stimulus row: a register write or an attempt item
    typedef struct {
        bit                 is_reg;
        logic [1:0]         reg_index;
        logic [COUNT_W-1:0] reg_value;
        bit                 attempt_ok;
        bit                 has_plan;
        attempt_plan_t      plan;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = CFG_SUBTICKS;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    // model registers and state
    logic [SUB_W-1:0]     subticks_reg;
    logic [STRIDE_W-1:0]  stride_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [63:0]          position;
    logic [SUB_W-1:0]     step_size;
    logic [COUNT_W-1:0]   step_count;
    logic                 freeze_flag;

    attempt_plan_t        next_attempt_q[$];
    stim_row_t            directed_rows[$];

    bit idle_en        = 1'b1;
    int errors         = 0;
    int results_seen   = 0;
    int attempts_live  = 0;
    int attempts_idle  = 0;
    int reg_writes     = 0;

    adaptive_step_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // hard stop
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // model: apply one attempt item and return the plan for the next attempt
    function automatic attempt_plan_t next_attempt(bit ok);
        longint unsigned msize, stride_eff, period, nxt, grow, room, ns;
        bit              done;
        attempt_plan_t   p;
        msize      = (subticks_reg == 0) ? 1 : longint'(subticks_reg);
        stride_eff = (stride_reg == 0) ? 1 : longint'(stride_reg);
        period     = stride_eff * msize;
        if (step_count < total_reg) begin
            if (ok || step_size[0]) begin
                // success, or an odd size pushed through
                nxt = (position + 64'(step_size)) & POS_MASK;
                if (nxt % msize == 0 && step_count != COUNT_MAX)
                    step_count = step_count + 1'b1;
                position = nxt;
                if (ok) begin
                    grow = 2 * longint'(step_size);
                    room = msize - (position % msize);
                    ns   = msize;
                    if (grow < ns) ns = grow;
                    if (room < ns) ns = room;
                    step_size = ns[SUB_W-1:0];
                end else begin
                    freeze_flag = 1'b1;
                end
            end else begin
                step_size = step_size >> 1;
            end
        end
        done             = step_count >= total_reg;
        p.position_ticks = position[39:0];
        p.step_ticks     = step_size;
        p.whole_steps    = step_count;
        p.sample_index   = COUNT_W'(longint'(step_count) / stride_eff);
        p.record_now     = done || (position % period == 0);
        p.record_next    = (((position + 64'(step_size)) & POS_MASK) % period) == 0;
        p.frozen         = freeze_flag;
        p.finished       = done;
        return p;
    endfunction

    task automatic report_field(string name, longint unsigned want, longint unsigned got);
        $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
        errors++;
    endtask

    // result monitor
    always @(posedge aclk) begin
        attempt_plan_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[39:0], m_tdata[52:40], m_tdata[73:53], m_tdata[94:74],
                   m_tdata[95], m_tdata[96], m_tdata[97], m_tdata[98]};
            results_seen++;
            if (next_attempt_q.size() == 0) begin
                $display("[%0t] unexpected result item, data 0x%0h", $time, m_tdata);
                errors++;
            end else begin
                want = next_attempt_q.pop_front();
                if (got.position_ticks !== want.position_ticks)
                    report_field("position_ticks", want.position_ticks, got.position_ticks);
                if (got.step_ticks !== want.step_ticks)
                    report_field("step_ticks", want.step_ticks, got.step_ticks);
                if (got.whole_steps !== want.whole_steps)
                    report_field("whole_steps", want.whole_steps, got.whole_steps);
                if (got.sample_index !== want.sample_index)
                    report_field("sample_index", want.sample_index, got.sample_index);
                if (got.record_now !== want.record_now)
                    report_field("record_now", want.record_now, got.record_now);
                if (got.record_next !== want.record_next)
                    report_field("record_next", want.record_next, got.record_next);
                if (got.frozen !== want.frozen)
                    report_field("frozen", want.frozen, got.frozen);
                if (got.finished !== want.finished)
                    report_field("finished", want.finished, got.finished);
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready = !idle_en || ($urandom_range(0, 99) >= 12);
    end

    // register write, issued only once every pending result has come back
    task automatic write_reg(logic [1:0] idx, logic [COUNT_W-1:0] value);
        @(negedge aclk);
        s_tvalid  = 1'b0;
        while (next_attempt_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_SUBTICKS: subticks_reg = value[SUB_W-1:0];
            CFG_STRIDE:   stride_reg   = value[STRIDE_W-1:0];
            CFG_TOTAL:    total_reg    = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // send one attempt item; a typed plan, when given, replaces the model's
    task automatic send_attempt(bit ok, bit has_plan, attempt_plan_t plan);
        attempt_plan_t p;
        @(negedge aclk);
        while (idle_en && $urandom_range(0, 99) < 12) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'b0, ok};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (step_count < total_reg) attempts_live++;
        else attempts_idle++;
        p = next_attempt(ok);
        next_attempt_q.push_back(has_plan ? plan : p);
    endtask

    function automatic void add_attempt(bit ok);
        stim_row_t r;
        r = '{default: '0};
        r.attempt_ok = ok;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [COUNT_W-1:0] value);
        stim_row_t r;
        r = '{default: '0};
        r.is_reg    = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_checked(bit ok, attempt_plan_t plan);
        stim_row_t r;
        r = '{default: '0};
        r.attempt_ok = ok;
        r.has_plan   = 1'b1;
        r.plan       = plan;
        directed_rows.push_back(r);
    endfunction

    // stimulus
    initial begin
        stim_row_t          row;
        attempt_plan_t      none;
        int                 phase;
        int                 n_items;
        int                 overrun;
        int                 pick;
        logic [COUNT_W-1:0] new_sub, new_stride, new_total;

        none         = '0;
        subticks_reg = SUBTICKS_RST;
        stride_reg   = STRIDE_RST;
        total_reg    = TOTAL_RST;
        position     = '0;
        step_size    = SUBTICKS_RST;
        step_count   = '0;
        freeze_flag  = 1'b0;

        // defaults after reset: full step lands on the first boundary
        add_checked(1'b1, '{position_ticks: 40'd128, step_ticks: 13'd128,
                            whole_steps: 21'd1, sample_index: 21'd1,
                            record_now: 1'b1, record_next: 1'b1,
                            frozen: 1'b0, finished: 1'b0});
        // failure on an even size halves it, position holds
        add_checked(1'b0, '{position_ticks: 40'd128, step_ticks: 13'd64,
                            whole_steps: 21'd1, sample_index: 21'd1,
                            record_now: 1'b1, record_next: 1'b0,
                            frozen: 1'b0, finished: 1'b0});
        add_attempt(1'b1);
        // halve down to one sub-tick, then force it through
        repeat (7) add_attempt(1'b0);
        add_attempt(1'b1);
        add_attempt(1'b1);
        // zero subticks acts as one; the held step exceeds it until a success
        add_reg(CFG_SUBTICKS, 21'd0);
        add_attempt(1'b1);
        add_attempt(1'b0);
        add_reg(CFG_STRIDE, 21'd0);
        add_attempt(1'b1);
        // zero total: already finished, items ignored
        add_reg(CFG_TOTAL, 21'd0);
        add_attempt(1'b1);
        add_attempt(1'b0);
        // largest legal sizes
        add_reg(CFG_SUBTICKS, 21'd4096);
        add_reg(CFG_STRIDE, 21'd1024);
        add_reg(CFG_TOTAL, 21'h1F_FFFF);
        add_attempt(1'b1);
        add_attempt(1'b1);
        add_attempt(1'b0);
        // all data bits set; upper bits are dropped by the narrower registers
        add_reg(CFG_SUBTICKS, 21'h1F_FFFF);
        add_reg(CFG_STRIDE, 21'h1F_FFFF);
        add_attempt(1'b1);
        add_attempt(1'b1);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed pass
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_reg) write_reg(row.reg_index, row.reg_value);
            else send_attempt(row.attempt_ok, row.has_plan, row.plan);
        end

        // random phases: new settings, then mostly successes until the run ends
        phase         = 0;
        attempts_live = 0;
        while (attempts_live < RAND_ATTEMPTS) begin
            // long stretch without idle cycles on either side
            idle_en = !(phase >= 3 && phase <= 5);

            pick = $urandom_range(0, 99);
            if (pick < 55)      new_sub = COUNT_W'($urandom_range(1, 16));
            else if (pick < 80) new_sub = 21'd1 << $urandom_range(0, 12);
            else if (pick < 95) new_sub = COUNT_W'($urandom_range(1, 4096));
            else                new_sub = 21'd4096;

            pick = $urandom_range(0, 99);
            if (pick < 80)      new_stride = COUNT_W'($urandom_range(1, 4));
            else if (pick < 95) new_stride = COUNT_W'($urandom_range(1, 1024));
            else                new_stride = 21'd1024;

            pick = $urandom_range(0, 99);
            if (pick < 10)      new_total = step_count;
            else if (pick < 15) new_total = 21'd1048576;
            else                new_total = step_count + COUNT_W'($urandom_range(2, 12));

            write_reg(CFG_SUBTICKS, new_sub);
            write_reg(CFG_STRIDE, new_stride);
            write_reg(CFG_TOTAL, new_total);

            n_items = $urandom_range(15, 40);
            overrun = 0;
            for (int k = 0; k < n_items; k++) begin
                send_attempt($urandom_range(0, 99) < 65, 1'b0, none);
                if (step_count >= total_reg) begin
                    overrun++;
                    if (overrun > 2) break;
                end
            end
            phase++;
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (next_attempt_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d random phases; %0d attempts advanced the run, %0d hit a finished run",
                 phase, attempts_live, attempts_idle);
        $display("%0d register writes, %0d result items checked, %0d mismatches",
                 reg_writes, results_seen, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/astep_pkg.sv
sv/astep_div.sv
sv/adaptive_step_sequencer.sv
tb/tb_top.sv
